@@ design/svi_pkg.sv @@
// ----------------------------------------------------------------------------
// svi_pkg
// Shared types, constants and arithmetic helpers of the steered velocity
// integrator: sequencer states, datapath commands and saturation functions.
// ----------------------------------------------------------------------------
package svi_pkg;

  localparam int unsigned MaxForces = 8;
  localparam int unsigned SlotW     = (MaxForces > 1) ? $clog2(MaxForces) : 1;
  localparam int unsigned CntW      = 6;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 64;
  localparam logic [30:0] GainReset = 31'd65536;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_M_DXG,
    CMD_M_DYG,
    CMD_M_SXDT,
    CMD_M_SYDT,
    CMD_M_SXSX,
    CMD_M_SYSY,
    CMD_M_GG,
    CMD_CMP,
    CMD_SQRT,
    CMD_M_SXG,
    CMD_DIV_LD,
    CMD_DIV,
    CMD_DIV_SX,
    CMD_DIV_SY,
    CMD_VEL,
    CMD_SLOT_AGE,
    CMD_SLOT_FY,
    CMD_SLOT_ADDY,
    CMD_M_PX,
    CMD_M_PY,
    CMD_POS_Y,
    CMD_OUT
  } cmd_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD,
    ST_M_DXG,
    ST_M_DYG,
    ST_M_SXDT,
    ST_M_SYDT,
    ST_M_SXSX,
    ST_M_SYSY,
    ST_M_GG,
    ST_CMP,
    ST_SQRT,
    ST_M_SXG,
    ST_DIVX_LD,
    ST_DIVX,
    ST_DIV_SX,
    ST_DIVY_LD,
    ST_DIVY,
    ST_DIV_SY,
    ST_VEL,
    ST_SLOT_AGE,
    ST_SLOT_FY,
    ST_SLOT_ADDY,
    ST_M_PX,
    ST_M_PY,
    ST_POS_Y,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e             op;
    logic [SlotW-1:0] slot;
  } dp_cmd_t;

  typedef struct packed {
    logic big;
    logic slot_act;
    logic out_busy;
  } dp_stat_t;

  // signed result from a magnitude and a sign, saturated to 32 bits
  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag >= 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  // product magnitude >> 16, signed and saturated
  function automatic logic [31:0] mulq(input logic [64:0] prod, input logic neg);
    return sat_mag({15'd0, prod[64:16]}, neg);
  endfunction

  // saturating signed 32-bit add
  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

endpackage

@@ design/svi_ctrl.sv @@
// ----------------------------------------------------------------------------
// svi_ctrl
// Sequencer of the integrator: walks the steps of a tick or an add-force
// item and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module svi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_ready_o,
  input  svi_pkg::dp_stat_t stat_i,
  output svi_pkg::dp_cmd_t  cmd_o
);

  svi_pkg::state_e state_q, state_d;
  logic [svi_pkg::CntW-1:0] cnt_q, cnt_d;

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svi_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      svi_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = func_i ? svi_pkg::ST_ADD : svi_pkg::ST_M_DXG;
      end
      svi_pkg::ST_ADD:    state_d = svi_pkg::ST_DONE;
      svi_pkg::ST_M_DXG:  state_d = svi_pkg::ST_M_DYG;
      svi_pkg::ST_M_DYG:  state_d = svi_pkg::ST_M_SXDT;
      svi_pkg::ST_M_SXDT: state_d = svi_pkg::ST_M_SYDT;
      svi_pkg::ST_M_SYDT: state_d = svi_pkg::ST_M_SXSX;
      svi_pkg::ST_M_SXSX: state_d = svi_pkg::ST_M_SYSY;
      svi_pkg::ST_M_SYSY: state_d = svi_pkg::ST_M_GG;
      svi_pkg::ST_M_GG:   state_d = svi_pkg::ST_CMP;
      svi_pkg::ST_CMP: begin
        cnt_d   = '0;
        state_d = stat_i.big ? svi_pkg::ST_SQRT : svi_pkg::ST_VEL;
      end
      svi_pkg::ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svi_pkg::CntW'(svi_pkg::SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = svi_pkg::ST_M_SXG;
        end
      end
      svi_pkg::ST_M_SXG:   state_d = svi_pkg::ST_DIVX_LD;
      svi_pkg::ST_DIVX_LD: state_d = svi_pkg::ST_DIVX;
      svi_pkg::ST_DIVX: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svi_pkg::CntW'(svi_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = svi_pkg::ST_DIV_SX;
        end
      end
      svi_pkg::ST_DIV_SX:  state_d = svi_pkg::ST_DIVY_LD;
      svi_pkg::ST_DIVY_LD: state_d = svi_pkg::ST_DIVY;
      svi_pkg::ST_DIVY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svi_pkg::CntW'(svi_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = svi_pkg::ST_DIV_SY;
        end
      end
      svi_pkg::ST_DIV_SY: state_d = svi_pkg::ST_VEL;
      svi_pkg::ST_VEL: begin
        cnt_d   = '0;
        state_d = svi_pkg::ST_SLOT_AGE;
      end
      svi_pkg::ST_SLOT_AGE: begin
        if (stat_i.slot_act) begin
          state_d = svi_pkg::ST_SLOT_FY;
        end else if (cnt_q == svi_pkg::CntW'(svi_pkg::MaxForces - 1)) begin
          state_d = svi_pkg::ST_M_PX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      svi_pkg::ST_SLOT_FY: state_d = svi_pkg::ST_SLOT_ADDY;
      svi_pkg::ST_SLOT_ADDY: begin
        if (cnt_q == svi_pkg::CntW'(svi_pkg::MaxForces - 1)) begin
          state_d = svi_pkg::ST_M_PX;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = svi_pkg::ST_SLOT_AGE;
        end
      end
      svi_pkg::ST_M_PX:  state_d = svi_pkg::ST_M_PY;
      svi_pkg::ST_M_PY:  state_d = svi_pkg::ST_POS_Y;
      svi_pkg::ST_POS_Y: state_d = svi_pkg::ST_DONE;
      svi_pkg::ST_DONE: begin
        if (!stat_i.out_busy) state_d = svi_pkg::ST_IDLE;
      end
      default: state_d = svi_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.slot  = cnt_q[svi_pkg::SlotW-1:0];
    cmd_o.op    = svi_pkg::CMD_NONE;
    unique case (state_q)
      svi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = svi_pkg::CMD_LOAD;
      end
      svi_pkg::ST_ADD:       cmd_o.op = svi_pkg::CMD_ADD;
      svi_pkg::ST_M_DXG:     cmd_o.op = svi_pkg::CMD_M_DXG;
      svi_pkg::ST_M_DYG:     cmd_o.op = svi_pkg::CMD_M_DYG;
      svi_pkg::ST_M_SXDT:    cmd_o.op = svi_pkg::CMD_M_SXDT;
      svi_pkg::ST_M_SYDT:    cmd_o.op = svi_pkg::CMD_M_SYDT;
      svi_pkg::ST_M_SXSX:    cmd_o.op = svi_pkg::CMD_M_SXSX;
      svi_pkg::ST_M_SYSY:    cmd_o.op = svi_pkg::CMD_M_SYSY;
      svi_pkg::ST_M_GG:      cmd_o.op = svi_pkg::CMD_M_GG;
      svi_pkg::ST_CMP:       cmd_o.op = svi_pkg::CMD_CMP;
      svi_pkg::ST_SQRT:      cmd_o.op = svi_pkg::CMD_SQRT;
      svi_pkg::ST_M_SXG:     cmd_o.op = svi_pkg::CMD_M_SXG;
      svi_pkg::ST_DIVX_LD:   cmd_o.op = svi_pkg::CMD_DIV_LD;
      svi_pkg::ST_DIVX:      cmd_o.op = svi_pkg::CMD_DIV;
      svi_pkg::ST_DIV_SX:    cmd_o.op = svi_pkg::CMD_DIV_SX;
      svi_pkg::ST_DIVY_LD:   cmd_o.op = svi_pkg::CMD_DIV_LD;
      svi_pkg::ST_DIVY:      cmd_o.op = svi_pkg::CMD_DIV;
      svi_pkg::ST_DIV_SY:    cmd_o.op = svi_pkg::CMD_DIV_SY;
      svi_pkg::ST_VEL:       cmd_o.op = svi_pkg::CMD_VEL;
      svi_pkg::ST_SLOT_AGE:  cmd_o.op = svi_pkg::CMD_SLOT_AGE;
      svi_pkg::ST_SLOT_FY:   cmd_o.op = svi_pkg::CMD_SLOT_FY;
      svi_pkg::ST_SLOT_ADDY: cmd_o.op = svi_pkg::CMD_SLOT_ADDY;
      svi_pkg::ST_M_PX:      cmd_o.op = svi_pkg::CMD_M_PX;
      svi_pkg::ST_M_PY:      cmd_o.op = svi_pkg::CMD_M_PY;
      svi_pkg::ST_POS_Y:     cmd_o.op = svi_pkg::CMD_POS_Y;
      svi_pkg::ST_DONE: begin
        if (!stat_i.out_busy) cmd_o.op = svi_pkg::CMD_OUT;
      end
      default: cmd_o.op = svi_pkg::CMD_NONE;
    endcase
  end

endmodule

@@ design/svi_dp.sv @@
// ----------------------------------------------------------------------------
// svi_dp
// Datapath of the integrator: motion state, force slots, one shared
// multiplier, bit-pair square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module svi_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svi_pkg::dp_cmd_t  cmd_i,
  output svi_pkg::dp_stat_t stat_o,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic [17:0]       dt_i,
  input  logic [31:0]       target_vx_i,
  input  logic [31:0]       target_vy_i,
  input  logic [31:0]       force_x_i,
  input  logic [31:0]       force_y_i,
  input  logic [30:0]       force_duration_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       vel_x_o,
  output logic [31:0]       vel_y_o,
  output logic [31:0]       pos_x_o,
  output logic [31:0]       pos_y_o,
  output logic              force_dropped_o
);

  localparam int unsigned NF    = svi_pkg::MaxForces;
  localparam int unsigned SlotW = svi_pkg::SlotW;

  // control state
  logic [30:0]   gain_q;
  logic [NF-1:0] live_q, live_d;
  logic [31:0]   vx_q, vx_d, vy_q, vy_d, px_q, px_d, py_q, py_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [17:0] dt_q;
  logic [31:0] tvx_q, tvy_q, fx_q, fy_q;
  logic [30:0] dur_q;
  logic [31:0] sx_q, sx_d, sy_q, sy_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] sqv_q, sqv_d, dv_q, dv_d;
  logic [34:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic        neg_q, neg_d;
  logic [64:0] prod_q;
  logic [31:0] slot_fx_q [NF];
  logic [31:0] slot_fy_q [NF];
  logic [31:0] slot_t_q  [NF];
  logic [31:0] ovx_q, ovy_q, opx_q, opy_q;
  logic        odrop_q, drop_q, drop_d;

  // multiplier operands
  logic [32:0] mul_a;
  logic [31:0] mul_b;

  // helpers
  logic [32:0]      dx, dy, t_new;
  logic [31:0]      mq;
  logic [34:0]      sq_rem, sq_trial;
  logic [33:0]      dv_rem;
  logic             free_any;
  logic [SlotW-1:0] free_idx;
  logic             slot_wr;

  assign dx    = {tvx_q[31], tvx_q} - {vx_q[31], vx_q};
  assign dy    = {tvy_q[31], tvy_q} - {vy_q[31], vy_q};
  assign mq    = svi_pkg::mulq(prod_q, neg_q);
  assign t_new = {slot_t_q[cmd_i.slot][31], slot_t_q[cmd_i.slot]} - {15'd0, dt_q};

  // bit-pair square root step
  assign sq_rem   = {rem_q[32:0], sqv_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  // restoring divide step, divisor is the root
  assign dv_rem   = {rem_q[32:0], dv_q[63]};

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  assign slot_wr = (cmd_i.op == svi_pkg::CMD_ADD) && free_any;

  // status to the sequencer
  assign stat_o.big      = acc_q > prod_q[63:0];
  assign stat_o.slot_act = live_q[cmd_i.slot] && !t_new[32];
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // command decode
  always_comb begin
    live_d      = live_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    px_d        = px_q;
    py_d        = py_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    acc_d       = acc_q;
    sqv_d       = sqv_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    root_d      = root_q;
    neg_d       = neg_q;
    drop_d      = drop_q;
    mul_a       = '0;
    mul_b       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      svi_pkg::CMD_NONE: ;
      svi_pkg::CMD_LOAD: drop_d = 1'b0;
      svi_pkg::CMD_ADD: begin
        drop_d = !free_any;
        if (free_any) live_d[free_idx] = 1'b1;
      end
      svi_pkg::CMD_M_DXG: begin
        neg_d = dx[32];
        mul_a = dx[32] ? (33'd0 - dx) : dx;
        mul_b = {1'b0, gain_q};
      end
      svi_pkg::CMD_M_DYG: begin
        sx_d  = mq;
        neg_d = dy[32];
        mul_a = dy[32] ? (33'd0 - dy) : dy;
        mul_b = {1'b0, gain_q};
      end
      svi_pkg::CMD_M_SXDT: begin
        sy_d  = mq;
        neg_d = sx_q[31];
        mul_a = {1'b0, svi_pkg::abs32(sx_q)};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_M_SYDT: begin
        sx_d  = mq;
        neg_d = sy_q[31];
        mul_a = {1'b0, svi_pkg::abs32(sy_q)};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_M_SXSX: begin
        sy_d  = mq;
        mul_a = {1'b0, svi_pkg::abs32(sx_q)};
        mul_b = svi_pkg::abs32(sx_q);
      end
      svi_pkg::CMD_M_SYSY: begin
        acc_d = prod_q[63:0];
        mul_a = {1'b0, svi_pkg::abs32(sy_q)};
        mul_b = svi_pkg::abs32(sy_q);
      end
      svi_pkg::CMD_M_GG: begin
        acc_d = acc_q + prod_q[63:0];
        mul_a = {2'b00, gain_q};
        mul_b = {1'b0, gain_q};
      end
      svi_pkg::CMD_CMP: begin
        sqv_d  = acc_q;
        rem_d  = '0;
        root_d = '0;
      end
      svi_pkg::CMD_SQRT: begin
        sqv_d = {sqv_q[61:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_d  = sq_rem - sq_trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = sq_rem;
          root_d = {root_q[30:0], 1'b0};
        end
      end
      svi_pkg::CMD_M_SXG: begin
        neg_d = sx_q[31];
        mul_a = {1'b0, svi_pkg::abs32(sx_q)};
        mul_b = {1'b0, gain_q};
      end
      svi_pkg::CMD_DIV_LD: begin
        dv_d  = prod_q[63:0];
        rem_d = '0;
      end
      svi_pkg::CMD_DIV: begin
        if (dv_rem >= {2'b00, root_q}) begin
          rem_d = {1'b0, dv_rem - {2'b00, root_q}};
          dv_d  = {dv_q[62:0], 1'b1};
        end else begin
          rem_d = {1'b0, dv_rem};
          dv_d  = {dv_q[62:0], 1'b0};
        end
      end
      svi_pkg::CMD_DIV_SX: begin
        sx_d  = svi_pkg::sat_mag(dv_q, neg_q);
        neg_d = sy_q[31];
        mul_a = {1'b0, svi_pkg::abs32(sy_q)};
        mul_b = {1'b0, gain_q};
      end
      svi_pkg::CMD_DIV_SY: sy_d = svi_pkg::sat_mag(dv_q, neg_q);
      svi_pkg::CMD_VEL: begin
        vx_d = svi_pkg::add_sat(vx_q, sx_q);
        vy_d = svi_pkg::add_sat(vy_q, sy_q);
      end
      svi_pkg::CMD_SLOT_AGE: begin
        if (live_q[cmd_i.slot] && t_new[32]) live_d[cmd_i.slot] = 1'b0;
        neg_d = slot_fx_q[cmd_i.slot][31];
        mul_a = {1'b0, svi_pkg::abs32(slot_fx_q[cmd_i.slot])};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_SLOT_FY: begin
        vx_d  = svi_pkg::add_sat(vx_q, mq);
        neg_d = slot_fy_q[cmd_i.slot][31];
        mul_a = {1'b0, svi_pkg::abs32(slot_fy_q[cmd_i.slot])};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_SLOT_ADDY: vy_d = svi_pkg::add_sat(vy_q, mq);
      svi_pkg::CMD_M_PX: begin
        neg_d = vx_q[31];
        mul_a = {1'b0, svi_pkg::abs32(vx_q)};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_M_PY: begin
        px_d  = svi_pkg::add_sat(px_q, mq);
        neg_d = vy_q[31];
        mul_a = {1'b0, svi_pkg::abs32(vy_q)};
        mul_b = {14'd0, dt_q};
      end
      svi_pkg::CMD_POS_Y: py_d = svi_pkg::add_sat(py_q, mq);
      svi_pkg::CMD_OUT:   out_valid_d = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= svi_pkg::GainReset;
      live_q      <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      live_q      <= live_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      px_q        <= px_d;
      py_q        <= py_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers and multiplier
  always_ff @(posedge clk_i) begin
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    acc_q  <= acc_d;
    sqv_q  <= sqv_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    neg_q  <= neg_d;
    drop_q <= drop_d;
    prod_q <= 65'(mul_a) * 65'(mul_b);
    if (cmd_i.op == svi_pkg::CMD_LOAD) begin
      dt_q  <= dt_i;
      tvx_q <= target_vx_i;
      tvy_q <= target_vy_i;
      fx_q  <= force_x_i;
      fy_q  <= force_y_i;
      dur_q <= force_duration_i;
    end
    if (cmd_i.op == svi_pkg::CMD_OUT) begin
      ovx_q   <= vx_q;
      ovy_q   <= vy_q;
      opx_q   <= px_q;
      opy_q   <= py_q;
      odrop_q <= drop_q;
    end
  end

  // force slot storage
  always_ff @(posedge clk_i) begin
    if (slot_wr) begin
      slot_fx_q[free_idx] <= fx_q;
      slot_fy_q[free_idx] <= fy_q;
      slot_t_q[free_idx]  <= {1'b0, dur_q};
    end else if (cmd_i.op == svi_pkg::CMD_SLOT_AGE && live_q[cmd_i.slot]) begin
      slot_t_q[cmd_i.slot] <= t_new[31:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vel_x_o         = ovx_q;
  assign vel_y_o         = ovy_q;
  assign pos_x_o         = opx_q;
  assign pos_y_o         = opy_q;
  assign force_dropped_o = odrop_q;

endmodule

@@ design/steered_velocity_integrator.sv @@
// ----------------------------------------------------------------------------
// steered_velocity_integrator
// Point-mass motion step in Q16.16: steering toward a target velocity with
// length clamp, timed forces, and position integration.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i/in_ready_o, func_i .. dur     | transfer in
//  out     | out_valid_o/out_ready_i, vel/pos/dropped | transfer out
//  cfg     | cfg_we_i, cfg_wdata_i (steer gain)       | write only
//
// add-force item: transfer in, then ST_ADD and ST_DONE, then result valid is registered
// tick: steering, a pass over all slots and position steps; a clamped
//   step adds a 32-step square root and two 64-step divides on one divider
// reset clears motion state and slot live bits; no clearing pass
// a waiting result is held while the next item is accepted and worked on;
//   a finished item waits until the previous result has been taken
// ----------------------------------------------------------------------------
module steered_velocity_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [17:0] dt_i,
  input  logic [31:0] target_vx_i,
  input  logic [31:0] target_vy_i,
  input  logic [31:0] force_x_i,
  input  logic [31:0] force_y_i,
  input  logic [30:0] force_duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] vel_x_o,
  output logic [31:0] vel_y_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic        force_dropped_o
);

  svi_pkg::dp_cmd_t  cmd;
  svi_pkg::dp_stat_t stat;

  // sequencer
  svi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  svi_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .dt_i             (dt_i),
    .target_vx_i      (target_vx_i),
    .target_vy_i      (target_vy_i),
    .force_x_i        (force_x_i),
    .force_y_i        (force_y_i),
    .force_duration_i (force_duration_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .vel_x_o          (vel_x_o),
    .vel_y_o          (vel_y_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .force_dropped_o  (force_dropped_o)
  );

  // an accepted item keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened right after a transfer");

  // a new result appears exactly as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while sequencer busy");

  // no new result appears right at the start of a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !func_i) |=> !out_valid_o || $past(out_valid_o))
    else $error("result appeared at tick start");

endmodule
